/* hdl/dual_parachute_deploy_sequencer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual deploy sequencer
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef DUAL_PARACHUTE_DEPLOY_SEQUENCER_UNIT_MACROS_SVH
`define DUAL_PARACHUTE_DEPLOY_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define DPDS_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication
`define DPDS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

/* hdl/dpds_pkg.sv */
// ----------------------------------------------------------------------------
// dpds_pkg
// Widths, reset values, codes and bundles of the dual deploy sequencer.
// ----------------------------------------------------------------------------
package dpds_pkg;

   localparam int ALT_W       = 24;
   localparam int ACC_W       = 15;
   localparam int RATE_W      = 19;
   localparam int LAUNCH_W    = 14;
   localparam int DROP_W      = 14;
   localparam int MAIN_ALT_W  = 23;
   localparam int MAIN_RATE_W = 18;

   localparam int ACC_SQ_W       = 2 * ACC_W - 1;
   localparam int RATE_SQ_W      = 2 * RATE_W - 1;
   localparam int ACC_SUM_W      = ACC_SQ_W + 2;
   localparam int RATE_SUM_W     = RATE_SQ_W + 1;
   localparam int LAUNCH_SQ_W    = 2 * LAUNCH_W;
   localparam int MAIN_RATE_SQ_W = 2 * MAIN_RATE_W;

   localparam int CSR_W     = 23;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

   localparam logic [LAUNCH_W-1:0]       LAUNCH_RST       = 14'd1500;
   localparam logic [DROP_W-1:0]         DROP_RST         = 14'd150;
   localparam logic [MAIN_ALT_W-1:0]     MAIN_ALT_RST     = 23'd10000;
   localparam logic [MAIN_RATE_W-1:0]    MAIN_RATE_RST    = 18'd2000;
   localparam logic [LAUNCH_SQ_W-1:0]    LAUNCH_SQ_RST    = 28'd2250000;
   localparam logic [MAIN_RATE_SQ_W-1:0] MAIN_RATE_SQ_RST = 36'd4000000;

   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_ALT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_RATE = 2'd3;

   localparam logic [1:0] PHASE_ASCENT = 2'd0;
   localparam logic [1:0] PHASE_DROGUE = 2'd1;
   localparam logic [1:0] PHASE_MAIN   = 2'd2;

   typedef enum logic [2:0] {
      ST_ASCENT = 3'b001,
      ST_DROGUE = 3'b010,
      ST_MAIN   = 3'b100
   } state_type;

   typedef struct packed {
      logic [LAUNCH_SQ_W-1:0]    launch_sq;
      logic [DROP_W-1:0]         drop;
      logic [MAIN_ALT_W-1:0]     main_alt;
      logic [MAIN_RATE_SQ_W-1:0] rate_sq;
   } thr_type;

   typedef struct packed {
      logic signed [ALT_W-1:0]  alt;
      logic signed [ACC_W-1:0]  ax;
      logic signed [ACC_W-1:0]  ay;
      logic signed [ACC_W-1:0]  az;
      logic signed [RATE_W-1:0] gx;
      logic signed [RATE_W-1:0] gy;
   } sample_type;

   typedef struct packed {
      logic signed [ALT_W-1:0] alt;
      logic [ACC_SQ_W-1:0]     ax_sq;
      logic [ACC_SQ_W-1:0]     ay_sq;
      logic [ACC_SQ_W-1:0]     az_sq;
      logic [RATE_SQ_W-1:0]    gx_sq;
      logic [RATE_SQ_W-1:0]    gy_sq;
   } sq_type;

   typedef struct packed {
      logic                    armed;
      logic [1:0]              phase;
      logic                    drogue_fire;
      logic                    main_fire;
      logic signed [ALT_W-1:0] peak;
   } status_type;

endpackage

/* hdl/dpds_cfg.sv */
// ----------------------------------------------------------------------------
// dpds_cfg
// Threshold registers; the magnitude limits are kept squared.
// ----------------------------------------------------------------------------
module dpds_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [dpds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpds_pkg::CSR_W-1:0]       csr_wdata,
   output dpds_pkg::thr_type                thr
);

   logic [dpds_pkg::LAUNCH_W-1:0]       launch_ff;
   logic [dpds_pkg::DROP_W-1:0]         drop_ff;
   logic [dpds_pkg::MAIN_ALT_W-1:0]     main_alt_ff;
   logic [dpds_pkg::MAIN_RATE_W-1:0]    main_rate_ff;
   logic [dpds_pkg::LAUNCH_SQ_W-1:0]    launch_sq_ff, launch_sq_in;
   logic [dpds_pkg::MAIN_RATE_SQ_W-1:0] rate_sq_ff, rate_sq_in;

   assign launch_sq_in = dpds_pkg::LAUNCH_SQ_W'(launch_ff) * dpds_pkg::LAUNCH_SQ_W'(launch_ff);
   assign rate_sq_in   = dpds_pkg::MAIN_RATE_SQ_W'(main_rate_ff)
                       * dpds_pkg::MAIN_RATE_SQ_W'(main_rate_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff    <= dpds_pkg::LAUNCH_RST;
         drop_ff      <= dpds_pkg::DROP_RST;
         main_alt_ff  <= dpds_pkg::MAIN_ALT_RST;
         main_rate_ff <= dpds_pkg::MAIN_RATE_RST;
         launch_sq_ff <= dpds_pkg::LAUNCH_SQ_RST;
         rate_sq_ff   <= dpds_pkg::MAIN_RATE_SQ_RST;
      end else begin
         // squares are registered from the value registers and follow them in the next cycle
         launch_sq_ff <= launch_sq_in;
         rate_sq_ff   <= rate_sq_in;
         if (csr_wen) begin
            unique case (csr_index)
               dpds_pkg::CSR_LAUNCH:    launch_ff    <= csr_wdata[dpds_pkg::LAUNCH_W-1:0];
               dpds_pkg::CSR_DROP:      drop_ff      <= csr_wdata[dpds_pkg::DROP_W-1:0];
               dpds_pkg::CSR_MAIN_ALT:  main_alt_ff  <= csr_wdata[dpds_pkg::MAIN_ALT_W-1:0];
               dpds_pkg::CSR_MAIN_RATE: main_rate_ff <= csr_wdata[dpds_pkg::MAIN_RATE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign thr.launch_sq = launch_sq_ff;
   assign thr.drop      = drop_ff;
   assign thr.main_alt  = main_alt_ff;
   assign thr.rate_sq   = rate_sq_ff;

endmodule

/* hdl/dpds_square.sv */
// ----------------------------------------------------------------------------
// dpds_square
// Input register and squares of the sensor axes.
// ----------------------------------------------------------------------------
module dpds_square (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dpds_pkg::sample_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dpds_pkg::sq_type     out_data
);

   logic                 s1_v_ff;
   logic                 s1_adv;
   dpds_pkg::sample_type s1_ff;
   dpds_pkg::sq_type     sq_in;

   assign s1_adv   = !s1_v_ff || out_ready;
   assign in_ready = s1_adv;

   always_comb begin
      logic signed [2*dpds_pkg::ACC_W-1:0]  ax_w, ay_w, az_w;
      logic signed [2*dpds_pkg::RATE_W-1:0] gx_w, gy_w;
      logic signed [2*dpds_pkg::ACC_W-1:0]  ax_p, ay_p, az_p;
      logic signed [2*dpds_pkg::RATE_W-1:0] gx_p, gy_p;
      ax_w = {{dpds_pkg::ACC_W{s1_ff.ax[dpds_pkg::ACC_W-1]}}, s1_ff.ax};
      ay_w = {{dpds_pkg::ACC_W{s1_ff.ay[dpds_pkg::ACC_W-1]}}, s1_ff.ay};
      az_w = {{dpds_pkg::ACC_W{s1_ff.az[dpds_pkg::ACC_W-1]}}, s1_ff.az};
      gx_w = {{dpds_pkg::RATE_W{s1_ff.gx[dpds_pkg::RATE_W-1]}}, s1_ff.gx};
      gy_w = {{dpds_pkg::RATE_W{s1_ff.gy[dpds_pkg::RATE_W-1]}}, s1_ff.gy};
      ax_p = ax_w * ax_w;
      ay_p = ay_w * ay_w;
      az_p = az_w * az_w;
      gx_p = gx_w * gx_w;
      gy_p = gy_w * gy_w;
      // squares are non-negative and fit one bit under the full product
      sq_in.alt   = s1_ff.alt;
      sq_in.ax_sq = ax_p[dpds_pkg::ACC_SQ_W-1:0];
      sq_in.ay_sq = ay_p[dpds_pkg::ACC_SQ_W-1:0];
      sq_in.az_sq = az_p[dpds_pkg::ACC_SQ_W-1:0];
      sq_in.gx_sq = gx_p[dpds_pkg::RATE_SQ_W-1:0];
      sq_in.gy_sq = gy_p[dpds_pkg::RATE_SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) s1_ff <= in_data;
   end

   assign out_valid = s1_v_ff;
   assign out_data  = sq_in;

endmodule

/* hdl/dpds_track.sv */
// ----------------------------------------------------------------------------
// dpds_track
// Arming, peak tracking and deploy sequencing, with the result register.
// ----------------------------------------------------------------------------
module dpds_track (
   input  logic                 clock,
   input  logic                 reset,
   input  dpds_pkg::thr_type    thr,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dpds_pkg::sq_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dpds_pkg::status_type out_data
);

   logic                              armed_ff, armed_in;
   dpds_pkg::state_type               state_ff, state_in;
   logic signed [dpds_pkg::ALT_W-1:0] peak_ff, peak_in;
   logic                              out_v_ff;
   dpds_pkg::status_type              out_ff, status_in;
   logic                              take;

   assign in_ready = !out_v_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      logic [dpds_pkg::ACC_SUM_W-1:0]    acc_sum;
      logic [dpds_pkg::RATE_SUM_W-1:0]   rate_sum;
      logic signed [dpds_pkg::ALT_W:0]   alt_x, drop_x, main_x, diff;
      acc_sum  = dpds_pkg::ACC_SUM_W'(in_data.ax_sq) + dpds_pkg::ACC_SUM_W'(in_data.ay_sq)
               + dpds_pkg::ACC_SUM_W'(in_data.az_sq);
      rate_sum = dpds_pkg::RATE_SUM_W'(in_data.gx_sq) + dpds_pkg::RATE_SUM_W'(in_data.gy_sq);
      alt_x    = {in_data.alt[dpds_pkg::ALT_W-1], in_data.alt};
      drop_x   = {{(dpds_pkg::ALT_W+1-dpds_pkg::DROP_W){1'b0}}, thr.drop};
      main_x   = {{(dpds_pkg::ALT_W+1-dpds_pkg::MAIN_ALT_W){1'b0}}, thr.main_alt};

      armed_in = armed_ff || (acc_sum > dpds_pkg::ACC_SUM_W'(thr.launch_sq));
      peak_in  = peak_ff;
      state_in = state_ff;

      // each check sees what the ones before it did in this sample
      if (armed_in) begin
         if (state_ff == dpds_pkg::ST_ASCENT && in_data.alt > peak_ff)
            peak_in = in_data.alt;
         diff = {peak_in[dpds_pkg::ALT_W-1], peak_in} - alt_x;
         if (state_ff == dpds_pkg::ST_ASCENT && diff > drop_x)
            state_in = dpds_pkg::ST_DROGUE;
         if (state_in == dpds_pkg::ST_DROGUE && alt_x < main_x &&
             rate_sum < dpds_pkg::RATE_SUM_W'(thr.rate_sq))
            state_in = dpds_pkg::ST_MAIN;
      end else begin
         diff = '0;
      end

      status_in.armed = armed_in;
      status_in.peak  = peak_in;
      unique case (state_in)
         dpds_pkg::ST_ASCENT: begin
            status_in.phase       = dpds_pkg::PHASE_ASCENT;
            status_in.drogue_fire = 1'b0;
            status_in.main_fire   = 1'b0;
         end
         dpds_pkg::ST_DROGUE: begin
            status_in.phase       = dpds_pkg::PHASE_DROGUE;
            status_in.drogue_fire = 1'b1;
            status_in.main_fire   = 1'b0;
         end
         dpds_pkg::ST_MAIN: begin
            status_in.phase       = dpds_pkg::PHASE_MAIN;
            status_in.drogue_fire = 1'b1;
            status_in.main_fire   = 1'b1;
         end
         default: begin
            status_in.phase       = dpds_pkg::PHASE_ASCENT;
            status_in.drogue_fire = 1'b0;
            status_in.main_fire   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         state_ff <= dpds_pkg::ST_ASCENT;
         peak_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (take) begin
            armed_ff <= armed_in;
            state_ff <= state_in;
            peak_ff  <= peak_in;
         end
         if (in_ready) out_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_ff <= status_in;
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

/* hdl/dual_parachute_deploy_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// dual_parachute_deploy_sequencer_unit
// Datapath: input register, one pass of squares and compares, result reg.
// Throughput one word per cycle; a held result word backs up into req_tready.
// Synchronous active-high reset clears flight state and restores thresholds.
// ----------------------------------------------------------------------------
`include "dual_parachute_deploy_sequencer_unit_macros.svh"

module dual_parachute_deploy_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // alt[23:0] ax[38:24] ay[53:39] az[68:54] gx[87:69] gy[106:88]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dpds_pkg::REQ_DATA_W-1:0]     req_tdata,
   // armed[0] phase[2:1] drogue_fire[3] main_fire[4] peak_altitude[28:5]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dpds_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [dpds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dpds_pkg::CSR_W-1:0]          csr_wdata
);

   dpds_pkg::thr_type    thr;
   dpds_pkg::sample_type sample;
   dpds_pkg::sq_type     sq_data;
   dpds_pkg::status_type rsp_status;
   logic                 sq_valid, sq_ready;

   assign sample.alt = req_tdata[23:0];
   assign sample.ax  = req_tdata[38:24];
   assign sample.ay  = req_tdata[53:39];
   assign sample.az  = req_tdata[68:54];
   assign sample.gx  = req_tdata[87:69];
   assign sample.gy  = req_tdata[106:88];

   dpds_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .thr       (thr)
   );

   dpds_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (sample),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_data  (sq_data)
   );

   dpds_track u_track (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_status)
   );

   assign rsp_tdata = {3'b000, rsp_status.peak, rsp_status.main_fire,
                       rsp_status.drogue_fire, rsp_status.phase, rsp_status.armed};

   // fire outputs and armed flag are latched from word to word
   `DPDS_CHECK_NEXT(a_main_latched, rsp_tvalid && rsp_status.main_fire, rsp_status.main_fire, "main_fire dropped after firing")
   `DPDS_CHECK_NEXT(a_armed_latched, rsp_tvalid && rsp_status.armed, rsp_status.armed, "armed dropped after arming")
   `DPDS_CHECK_NOW(a_drogue_phase, rsp_tvalid, rsp_status.drogue_fire == (rsp_status.phase != dpds_pkg::PHASE_ASCENT), "drogue_fire disagrees with phase")

endmodule
